FILE: rtl/ostb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ostb_pkg;

   localparam int SLOTS      = 8;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TICK_W     = 32;

   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_SET    = 3'd1;
   localparam logic [2:0] MODE_QUERY  = 3'd2;
   localparam logic [2:0] MODE_CLEAR  = 3'd3;
   localparam logic [2:0] MODE_INLINE = 3'd4;

   localparam logic [1:0] UNIT_ONE     = 2'd0;
   localparam logic [1:0] UNIT_TEN     = 2'd1;
   localparam logic [1:0] UNIT_HUNDRED = 2'd2;

   typedef logic [TICK_W-1:0] tick_type;

endpackage

`default_nettype wire

FILE: rtl/one_shot_timer_bank_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Bank of one-shot deadline timers on a 32-bit tick count that advances on
// tick requests. Each request is a tick, set, query, clear or inline
// set-then-query on one slot and returns exactly one response carrying the
// expired flag (zero for tick, set, clear and the unused modes). Two register
// stages: the request register holds the operation with its duration already
// scaled by 1, 10 or 100, and the response register captures the flag while
// the slot state and tick count are updated in the same cycle. One transaction
// is taken per cycle while the response side is not stalled; response valid
// rises as the request register hands over to the response register, and a
// stalled response holds the request stage until it is taken.
// Expiry is a plain unsigned compare of deadline against the tick count.
module one_shot_timer_bank_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [2:0]              req_mode,
   input  wire logic [2:0]              req_slot,
   input  wire logic [31:0]             req_duration,
   input  wire logic [1:0]              req_unit,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_expired
);
   import ostb_pkg::*;

   // request stage
   logic                  s1_vld_ff, s1_vld_in;
   logic [2:0]            s1_mode_ff;
   logic [2:0]            s1_slot_ff;
   tick_type              s1_dur_ff, s1_dur_in;

   // response stage
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  rsp_exp_ff, rsp_exp_in;

   // timer state
   tick_type              now_ff, now_in;
   logic [SLOTS-1:0]      armed_ff, armed_in;
   tick_type              deadline_ff [SLOTS];

   logic                  req_fire;
   logic                  s2_adv;
   logic                  slot_ok;
   logic [SLOT_IDX_W-1:0] idx;
   logic                  cur_armed;
   tick_type              new_deadline;
   tick_type              eff_deadline;
   logic                  eff_armed;
   logic                  dl_we;

   assign s2_adv    = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s2_adv;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_expired = rsp_exp_ff;

   // scale the duration at the input: x10 = 8+2, x100 = 64+32+4
   always_comb begin
      case (req_unit)
         UNIT_TEN:     s1_dur_in = (req_duration << 3) + (req_duration << 1);
         UNIT_HUNDRED: s1_dur_in = (req_duration << 6) + (req_duration << 5)
                                   + (req_duration << 2);
         default:      s1_dur_in = req_duration;
      endcase
   end

   assign s1_vld_in = req_fire ? 1'b1 : (s2_adv ? 1'b0 : s1_vld_ff);

   assign slot_ok      = ({29'd0, s1_slot_ff} < 32'(SLOTS));
   assign idx          = SLOT_IDX_W'(s1_slot_ff);
   assign cur_armed    = slot_ok && armed_ff[idx];
   assign new_deadline = now_ff + s1_dur_ff;

   always_comb begin
      now_in       = now_ff;
      armed_in     = armed_ff;
      rsp_exp_in   = 1'b0;
      dl_we        = 1'b0;
      eff_deadline = deadline_ff[idx];
      eff_armed    = cur_armed;
      unique case (s1_mode_ff)
         MODE_TICK: begin
            now_in = now_ff + 1'b1;
         end
         MODE_SET: begin
            if (slot_ok && !cur_armed) begin
               dl_we         = 1'b1;
               armed_in[idx] = 1'b1;
            end
         end
         MODE_QUERY: begin
            rsp_exp_in = cur_armed && (eff_deadline <= now_ff);
         end
         MODE_CLEAR: begin
            if (slot_ok) begin
               armed_in[idx] = 1'b0;
            end
         end
         MODE_INLINE: begin
            if (slot_ok && !cur_armed) begin
               dl_we         = 1'b1;
               armed_in[idx] = 1'b1;
               eff_deadline  = new_deadline;
               eff_armed     = 1'b1;
            end
            rsp_exp_in = eff_armed && (eff_deadline <= now_ff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_vld_in = s2_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         now_ff     <= '0;
         armed_ff   <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (s2_adv) begin
            now_ff   <= now_in;
            armed_ff <= armed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff <= req_mode;
         s1_slot_ff <= req_slot;
         s1_dur_ff  <= s1_dur_in;
      end
      if (s2_adv) begin
         rsp_exp_ff <= rsp_exp_in;
      end
      // deadline is only read while armed, so it needs no reset
      if (s2_adv && dl_we) begin
         deadline_ff[idx] <= new_deadline;
      end
   end

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      s2_adv && (s1_mode_ff == MODE_TICK) |=> now_ff == $past(now_ff) + 1'b1)
      else $error("tick count did not advance on a tick transaction");

   a_clear_disarms: assert property (@(posedge clock) disable iff (reset)
      s2_adv && (s1_mode_ff == MODE_CLEAR) && slot_ok |=> !armed_ff[$past(idx)])
      else $error("slot still armed after clear");

   a_hold_when_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_vld_ff && rsp_vld_ff && !rsp_ready)
      else $error("request side stalled without a full pipeline");

   a_state_frozen: assert property (@(posedge clock) disable iff (reset)
      !s2_adv |=> $stable(now_ff) && $stable(armed_ff))
      else $error("timer state changed without a transaction");

endmodule

`default_nettype wire

FILE: tb/sv/one_shot_timer_bank_core_tb.sv
`timescale 1ns / 1ps

module one_shot_timer_bank_core_tb;

   import ostb_pkg::*;

   typedef struct {
      logic [2:0]  mode;
      logic [2:0]  slot;
      tick_type    duration;
      logic [1:0]  unit;
      int unsigned gap;
      bit          drain;
   } timer_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = MODE_TICK;
   logic [2:0]  req_slot = '0;
   logic [31:0] req_duration = '0;
   logic [1:0]  req_unit = UNIT_ONE;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_expired;

   timer_op_type pending_ops[$];
   logic        expiry_expected[$];
   int unsigned mismatch_count = 0;
   int unsigned rsp_seen = 0;
   int unsigned rsp_stall = 0;
   bit          sender_calm = 0;

   // predictor state
   tick_type               model_now = '0;
   logic [SLOTS-1:0]       model_armed = '0;
   tick_type               model_deadline[SLOTS];

   one_shot_timer_bank_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_slot     (req_slot),
      .req_duration (req_duration),
      .req_unit     (req_unit),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_expired  (rsp_expired)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic got, input logic want);
      mismatch_count++;
      $display("ERROR %0t ns: %s (expired got %b, want %b)", $time, what, got, want);
   endtask

   function automatic tick_type scaled_length(input tick_type dur, input logic [1:0] unit);
      case (unit)
         UNIT_TEN:     return dur * 32'd10;
         UNIT_HUNDRED: return dur * 32'd100;
         default:      return dur;
      endcase
   endfunction

   function automatic logic slot_expired(input int unsigned s);
      return model_armed[s] && (model_deadline[s] <= model_now);
   endfunction

   task automatic predict_expiry(input logic [2:0] mode, input logic [2:0] slot,
                                 input tick_type dur, input logic [1:0] unit);
      int unsigned s;
      bit          in_range;
      logic        hit;
      s = 32'(slot);
      in_range = (s < SLOTS);
      hit = 1'b0;
      case (mode) inside
         MODE_TICK: model_now = model_now + 32'd1;
         MODE_SET, MODE_INLINE: begin
            if (in_range) begin
               if (!model_armed[s]) begin
                  model_deadline[s] = model_now + scaled_length(dur, unit);
                  model_armed[s] = 1'b1;
               end
               if (mode == MODE_INLINE) hit = slot_expired(s);
            end
         end
         MODE_QUERY: if (in_range) hit = slot_expired(s);
         MODE_CLEAR: if (in_range) model_armed[s] = 1'b0;
         default: ;
      endcase
      expiry_expected.push_back(hit);
   endtask

   task automatic add_op(input logic [2:0] mode, input logic [2:0] slot,
                         input tick_type dur, input logic [1:0] unit);
      timer_op_type op;
      op.mode = mode;
      op.slot = slot;
      op.duration = dur;
      op.unit = unit;
      op.gap = sender_calm ? 0 : $urandom_range(0, 8);
      op.drain = 0;
      pending_ops.push_back(op);
   endtask

   task automatic add_drain();
      timer_op_type op;
      op.mode = MODE_TICK;
      op.slot = '0;
      op.duration = '0;
      op.unit = UNIT_ONE;
      op.gap = 0;
      op.drain = 1;
      pending_ops.push_back(op);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_expiry(req_mode, req_slot, req_duration, req_unit);
         if (!(req_valid && !req_ready)) begin
            if (pending_ops.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_ops[0].drain) begin
               // hold off until the bank has answered everything
               req_valid <= 1'b0;
               if (expiry_expected.size() == 0) void'(pending_ops.pop_front());
            end else if (pending_ops[0].gap != 0) begin
               req_valid <= 1'b0;
               pending_ops[0].gap--;
            end else begin
               req_mode     <= pending_ops[0].mode;
               req_slot     <= pending_ops[0].slot;
               req_duration <= pending_ops[0].duration;
               req_unit     <= pending_ops[0].unit;
               req_valid    <= 1'b1;
               void'(pending_ops.pop_front());
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expiry_expected.size() == 0)
               report_mismatch("response with no transaction outstanding", rsp_expired, 1'b0);
            else if (rsp_expired !== expiry_expected[0])
               report_mismatch("wrong expired flag", rsp_expired, expiry_expected[0]);
            if (expiry_expected.size() != 0) void'(expiry_expected.pop_front());
            rsp_seen++;
            // every fourth stretch of 150 responses runs without back-pressure
            rsp_stall = (((rsp_seen / 150) % 4) == 2) ? 0 : $urandom_range(0, 8);
         end
         if (rsp_stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned n;
      int unsigned pick;
      logic [2:0]  mode;
      logic [2:0]  slot;
      tick_type    dur;
      logic [1:0]  unit;

      for (int i = 0; i < SLOTS; i++) model_deadline[i] = '0;

      // directed part
      add_op(MODE_QUERY,  3'd0, 32'd0, UNIT_ONE);          // idle slot reads 0
      add_op(MODE_SET,    3'd0, 32'd0, UNIT_ONE);          // deadline equals now
      add_op(MODE_QUERY,  3'd0, 32'd0, UNIT_ONE);
      add_op(MODE_SET,    3'd0, 32'd5, UNIT_HUNDRED);      // armed: keep old deadline
      add_op(MODE_QUERY,  3'd0, 32'd0, UNIT_ONE);
      add_op(MODE_CLEAR,  3'd0, 32'd0, UNIT_ONE);
      add_op(MODE_QUERY,  3'd0, 32'd0, UNIT_ONE);
      add_op(MODE_CLEAR,  3'd6, 32'hFFFF_FFFF, 2'd3);      // clear of an idle slot
      add_op(MODE_INLINE, 3'd1, 32'd1, UNIT_TEN);
      add_op(MODE_SET,    3'd7, 32'hFFFF_FFFF, UNIT_ONE);  // deadline far ahead, reads not expired
      add_op(MODE_QUERY,  3'd7, 32'd0, UNIT_ONE);
      add_op(MODE_INLINE, 3'd2, 32'hFFFF_FFFF, UNIT_HUNDRED);
      add_op(MODE_INLINE, 3'd3, 32'd2, 2'd3);              // unused unit scales by one
      add_op(MODE_TICK,   3'd5, 32'hAAAA_5555, UNIT_TEN);
      add_op(MODE_QUERY,  3'd3, 32'd0, UNIT_ONE);
      add_op(MODE_TICK,   3'd0, 32'd0, UNIT_ONE);
      add_op(MODE_INLINE, 3'd3, 32'd9, UNIT_ONE);          // armed: query only
      add_op(3'd5,        3'd4, 32'h5555_AAAA, UNIT_ONE);  // unused modes
      add_op(3'd6,        3'd4, 32'd1, UNIT_ONE);
      add_op(3'd7,        3'd7, 32'd1, 2'd3);
      add_op(MODE_QUERY,  3'd4, 32'd0, UNIT_ONE);
      add_op(MODE_SET,    3'd4, 32'hFFFF_FFFF, UNIT_TEN);
      add_op(MODE_QUERY,  3'd1, 32'd0, UNIT_ONE);
      add_drain();

      // random part: mostly short timers so deadlines are reached by ticks
      for (n = 0; n < 1327; n++) begin
         sender_calm = ((n / 175) % 4) == 1;
         if (n % 450 == 449) add_drain();
         pick = $urandom_range(0, 99);
         slot = 3'($urandom_range(0, 7));
         unit = UNIT_ONE;
         dur = $urandom_range(0, 12);
         if (pick < 36) mode = MODE_TICK;
         else if (pick < 55) mode = MODE_SET;
         else if (pick < 75) mode = MODE_QUERY;
         else if (pick < 83) mode = MODE_CLEAR;
         else if (pick < 96) mode = MODE_INLINE;
         else mode = 3'($urandom_range(5, 7));
         pick = $urandom_range(0, 99);
         if (pick < 15) unit = UNIT_TEN;
         else if (pick < 20) unit = UNIT_HUNDRED;
         else if (pick < 25) unit = 2'd3;
         if (unit == UNIT_TEN || unit == UNIT_HUNDRED) dur = $urandom_range(0, 3);
         if ($urandom_range(0, 99) < 6) dur = $urandom;
         else if ($urandom_range(0, 99) < 3) dur = 32'hFFFF_FFFF - $urandom_range(0, 40);
         add_op(mode, slot, dur, unit);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
      while (expiry_expected.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
